// ===== rtl/core/osf_pkg.sv =====
// Shared types and constants of the orbit scale factor pipeline.
package osf_pkg;

  localparam int POS_W     = 48;
  localparam int VEL_W     = 32;
  localparam int MU_W      = 56;
  localparam int LEN_W     = 48;
  localparam int SPD_W     = 32;
  localparam int TIM_W     = 63;
  localparam int DEN_SHIFT = 57;
  localparam int LEN_SHIFT = 56;
  localparam int TIM_SHIFT = 160;
  localparam int DEN_W     = MU_W + DEN_SHIFT;

  localparam logic [MU_W-1:0] MU_RESET = 56'd102036172800;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] length_factor;
    logic [SPD_W-1:0] speed_factor;
    logic [TIM_W-1:0] time_factor;
    status_t          status;
  } out_item_t;

endpackage

// ===== rtl/core/osf_mul.sv =====
// Pipelined multiplier: one digit of the second operand per stage.
module osf_mul #(
  parameter int WA = 8,
  parameter int WB = 8,
  parameter int NS = 1,
  parameter int WS = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [WA-1:0]    in_a,
  input  logic [WB-1:0]    in_b,
  input  logic [WS-1:0]    in_side,
  output logic             out_valid,
  output logic [WA+WB-1:0] out_prod,
  output logic [WS-1:0]    out_side
);

  localparam int DW  = (WB + NS - 1) / NS;
  localparam int WBP = DW * NS;
  localparam int WP  = WA + WB;
  localparam int WPP = WA + DW;

  logic            v_r   [NS];
  logic [WA-1:0]   a_r   [NS];
  logic [WBP-1:0]  b_r   [NS];
  logic [WP-1:0]   acc_r [NS];
  logic [WS-1:0]   s_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic           v_in;
    logic [WA-1:0]  a_in;
    logic [WBP-1:0] b_in;
    logic [WP-1:0]  acc_in;
    logic [WS-1:0]  s_in;
    logic [WPP-1:0] pp;
    logic [WP-1:0]  acc_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign a_in   = in_a;
      assign b_in   = WBP'(in_b);
      assign acc_in = '0;
      assign s_in   = in_side;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
      assign s_in   = s_r[k-1];
    end

    assign pp      = WPP'(a_in) * WPP'(b_in[k*DW +: DW]);
    assign acc_nxt = acc_in + (WP'(pp) << (k * DW));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      a_r[k]   <= a_in;
      b_r[k]   <= b_in;
      acc_r[k] <= acc_nxt;
      s_r[k]   <= s_in;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_prod  = acc_r[NS-1];
  assign out_side  = s_r[NS-1];

endmodule

// ===== rtl/core/osf_seek.sv =====
// Pipelined restoring divider and scaled square root, one result bit per stage.
module osf_seek #(
  parameter int WN   = 8,
  parameter int WD   = 8,
  parameter int WQ   = 4,
  parameter int ROOT = 0,
  parameter int WS   = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [WN-1:0] in_num,
  input  logic [WD-1:0] in_den,
  input  logic [WS-1:0] in_side,
  output logic          out_valid,
  output logic [WQ-1:0] out_quo,
  output logic          out_sat,
  output logic [WS-1:0] out_side
);

  localparam int EXP = (ROOT != 0) ? 2 : 1;
  localparam int WT  = WD + EXP * WQ;
  localparam int W   = ((WN > WT) ? WN : WT) + 1;
  localparam int WX  = WQ + WD;

  logic          v_r    [WQ+1];
  logic [W-1:0]  rem_r  [WQ+1];
  logic [WX-1:0] td_r   [WQ+1];
  logic [WQ-1:0] quo_r  [WQ+1];
  logic [WD-1:0] den_r  [WQ+1];
  logic          sat_r  [WQ+1];
  logic [WS-1:0] side_r [WQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    rem_r[0]  <= W'(in_num);
    td_r[0]   <= '0;
    quo_r[0]  <= '0;
    den_r[0]  <= in_den;
    sat_r[0]  <= ((W'(in_den) << (EXP * WQ)) <= W'(in_num));
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k <= WQ; k++) begin : g_step
    localparam int B = WQ - k;
    logic [W-1:0]  cand;
    logic          take;
    logic [W-1:0]  rem_nxt;
    logic [WX-1:0] td_nxt;
    logic [WQ-1:0] quo_nxt;

    always_comb begin
      if (ROOT != 0) begin
        cand = (W'(td_r[k-1]) << (B + 1)) + (W'(den_r[k-1]) << (2 * B));
      end else begin
        cand = W'(den_r[k-1]) << B;
      end
      take    = (rem_r[k-1] >= cand);
      rem_nxt = take ? (rem_r[k-1] - cand) : rem_r[k-1];
      td_nxt  = take ? (td_r[k-1] + (WX'(den_r[k-1]) << B)) : td_r[k-1];
      quo_nxt    = quo_r[k-1];
      quo_nxt[B] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
      rem_r[k]  <= rem_nxt;
      td_r[k]   <= td_nxt;
      quo_r[k]  <= quo_nxt;
      den_r[k]  <= den_r[k-1];
      sat_r[k]  <= sat_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_valid = v_r[WQ];
  assign out_quo   = sat_r[WQ] ? '1 : quo_r[WQ];
  assign out_sat   = sat_r[WQ];
  assign out_side  = side_r[WQ];

endmodule

// ===== rtl/core/orbit_scale_factors.sv =====
// Top level of the orbit scale factor pipeline.
//
// Raise start for one cycle with a Cartesian state on in_item; busy is always low, so a
// new item may be given in every cycle. Each item yields exactly one result on out_item,
// marked by out_strobe for one cycle, in order of arrival. The receiver cannot stall.
// Each item passes through the pipeline stages of the squarers (6), the radius square
// root (49), the product stages (7, 15, 15), the time root (64), the length divider
// (49), the speed root (33) and three single registers. Throughput is one item per
// cycle. The one-bit-per-stage divider and square roots set the depth.
// cfg_we and cfg_wdata write the gravitational parameter; the user must do so only while
// no item is in flight, and the block itself does not enforce it. Reset clears every
// valid bit, dropping items in flight, and returns the gravitational parameter to Earth's value.
module orbit_scale_factors (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  osf_pkg::in_item_t       in_item,
  output logic                    out_strobe,
  output osf_pkg::out_item_t      out_item,
  input  logic                    cfg_we,
  input  logic [osf_pkg::MU_W-1:0] cfg_wdata
);

  import osf_pkg::*;

  localparam int NS_SQ = (((POS_W > VEL_W) ? POS_W : VEL_W) + 7) / 8;
  localparam int NS_P1 = (((POS_W > MU_W) ? POS_W : MU_W) + 7) / 8;
  localparam int NS_P2 = (((POS_W > DEN_W) ? POS_W : DEN_W) + 7) / 8;
  localparam int NS_P3 = (((DEN_W > 2 * MU_W) ? DEN_W : 2 * MU_W) + 7) / 8;
  localparam int WRV   = 2 * VEL_W + POS_W;
  localparam int WE    = ((DEN_W > WRV) ? DEN_W : WRV) + 1;
  localparam int LATENCY = NS_SQ + 1 + (POS_W + 1) + NS_P1 + 1 + NS_P2 + NS_P3
                         + (TIM_W + 1) + (LEN_W + 1) + (SPD_W + 1) + 1;

  typedef struct packed {
    logic                    bad;
    logic [POS_W-1:0]        rr;
    logic [MU_W+POS_W-1:0]   rm;
    logic [2*MU_W-1:0]       mm;
    logic [DEN_W-1:0]        den;
  } p2_side_t;

  typedef struct packed {
    logic                    bad;
    logic [POS_W-1:0]        rr;
    logic [MU_W+POS_W-1:0]   rm;
    logic [DEN_W-1:0]        den;
  } p3_side_t;

  typedef struct packed {
    logic              bad;
    logic [POS_W-1:0]  rr;
    logic [DEN_W-1:0]  den;
    logic [TIM_W-1:0]  tf;
    logic              tsat;
  } l_side_t;

  typedef struct packed {
    logic              bad;
    logic [TIM_W-1:0]  tf;
    logic              tsat;
    logic [LEN_W-1:0]  lf;
    logic              lsat;
  } s_side_t;

  logic [MU_W-1:0] grav_param_r;
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_param_r <= MU_RESET;
    end else if (cfg_we) begin
      grav_param_r <= cfg_wdata;
    end
  end

  // squares of the component magnitudes
  logic [POS_W-1:0]   pos_raw [3];
  logic [VEL_W-1:0]   vel_raw [3];
  logic [POS_W-1:0]   pos_mag [3];
  logic [VEL_W-1:0]   vel_mag [3];
  logic [2*POS_W-1:0] pos_sq  [3];
  logic [2*VEL_W-1:0] vel_sq  [3];
  logic [5:0]         sq_v;

  assign pos_raw[0] = in_item.pos_x;
  assign pos_raw[1] = in_item.pos_y;
  assign pos_raw[2] = in_item.pos_z;
  assign vel_raw[0] = in_item.vel_x;
  assign vel_raw[1] = in_item.vel_y;
  assign vel_raw[2] = in_item.vel_z;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign pos_mag[i] = pos_raw[i][POS_W-1] ? (~pos_raw[i] + 1'b1) : pos_raw[i];
    assign vel_mag[i] = vel_raw[i][VEL_W-1] ? (~vel_raw[i] + 1'b1) : vel_raw[i];

    osf_mul #(.WA(POS_W), .WB(POS_W), .NS(NS_SQ), .WS(1)) u_pos_sq (
      .clk, .rst_n, .in_valid(accept), .in_a(pos_mag[i]), .in_b(pos_mag[i]),
      .in_side(1'b0), .out_valid(sq_v[i]), .out_prod(pos_sq[i]), .out_side()
    );

    osf_mul #(.WA(VEL_W), .WB(VEL_W), .NS(NS_SQ), .WS(1)) u_vel_sq (
      .clk, .rst_n, .in_valid(accept), .in_a(vel_mag[i]), .in_b(vel_mag[i]),
      .in_side(1'b0), .out_valid(sq_v[i+3]), .out_prod(vel_sq[i]), .out_side()
    );
  end

  logic               sum_v_r;
  logic [2*POS_W-1:0] r2_r;
  logic [2*VEL_W-1:0] v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else begin
      sum_v_r <= &sq_v;
    end
    r2_r <= pos_sq[0] + pos_sq[1] + pos_sq[2];
    v2_r <= vel_sq[0] + vel_sq[1] + vel_sq[2];
  end

  // radius
  logic               rr_v;
  logic [POS_W-1:0]   rr;
  logic [2*VEL_W-1:0] rr_v2;

  osf_seek #(.WN(2*POS_W), .WD(1), .WQ(POS_W), .ROOT(1), .WS(2*VEL_W)) u_radius (
    .clk, .rst_n, .in_valid(sum_v_r), .in_num(r2_r), .in_den(1'b1), .in_side(v2_r),
    .out_valid(rr_v), .out_quo(rr), .out_sat(), .out_side(rr_v2)
  );

  // first products
  logic                  p1_v;
  logic [WRV-1:0]        rv;
  logic [POS_W-1:0]      p1_rr;
  logic [MU_W+POS_W-1:0] rm;
  logic [2*POS_W-1:0]    rr2;
  logic [2*MU_W-1:0]     mm;

  osf_mul #(.WA(2*VEL_W), .WB(POS_W), .NS(NS_P1), .WS(POS_W)) u_rv (
    .clk, .rst_n, .in_valid(rr_v), .in_a(rr_v2), .in_b(rr), .in_side(rr),
    .out_valid(p1_v), .out_prod(rv), .out_side(p1_rr)
  );

  osf_mul #(.WA(MU_W), .WB(POS_W), .NS(NS_P1), .WS(1)) u_rm (
    .clk, .rst_n, .in_valid(rr_v), .in_a(grav_param_r), .in_b(rr), .in_side(1'b0),
    .out_valid(), .out_prod(rm), .out_side()
  );

  osf_mul #(.WA(POS_W), .WB(POS_W), .NS(NS_P1), .WS(1)) u_rr2 (
    .clk, .rst_n, .in_valid(rr_v), .in_a(rr), .in_b(rr), .in_side(1'b0),
    .out_valid(), .out_prod(rr2), .out_side()
  );

  osf_mul #(.WA(MU_W), .WB(MU_W), .NS(NS_P1), .WS(1)) u_mm (
    .clk, .rst_n, .in_valid(rr_v), .in_a(grav_param_r), .in_b(grav_param_r),
    .in_side(1'b0), .out_valid(), .out_prod(mm), .out_side()
  );

  // denominator and invalid check
  logic [WE-1:0]         mu_top;
  logic [WE-1:0]         rv_x;
  logic [WE-1:0]         den_diff;
  logic                  e_v_r;
  logic                  bad_r;
  logic [DEN_W-1:0]      den_r;
  logic [POS_W-1:0]      rr_e_r;
  logic [MU_W+POS_W-1:0] rm_e_r;
  logic [2*POS_W-1:0]    rr2_e_r;
  logic [2*MU_W-1:0]     mm_e_r;

  assign mu_top   = WE'(grav_param_r) << DEN_SHIFT;
  assign rv_x     = WE'(rv);
  assign den_diff = mu_top - rv_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= p1_v;
    end
    bad_r   <= (p1_rr == '0) || (mu_top <= rv_x);
    den_r   <= den_diff[DEN_W-1:0];
    rr_e_r  <= p1_rr;
    rm_e_r  <= rm;
    rr2_e_r <= rr2;
    mm_e_r  <= mm;
  end

  // cubes
  p2_side_t             p2_in;
  p2_side_t             p2_out;
  logic                 p2_v;
  logic [3*POS_W-1:0]   rr3;
  logic [2*DEN_W-1:0]   den2;

  always_comb begin
    p2_in.bad = bad_r;
    p2_in.rr  = rr_e_r;
    p2_in.rm  = rm_e_r;
    p2_in.mm  = mm_e_r;
    p2_in.den = den_r;
  end

  osf_mul #(.WA(2*POS_W), .WB(POS_W), .NS(NS_P2), .WS($bits(p2_side_t))) u_rr3 (
    .clk, .rst_n, .in_valid(e_v_r), .in_a(rr2_e_r), .in_b(rr_e_r), .in_side(p2_in),
    .out_valid(p2_v), .out_prod(rr3), .out_side(p2_out)
  );

  osf_mul #(.WA(DEN_W), .WB(DEN_W), .NS(NS_P2), .WS(1)) u_den2 (
    .clk, .rst_n, .in_valid(e_v_r), .in_a(den_r), .in_b(den_r), .in_side(1'b0),
    .out_valid(), .out_prod(den2), .out_side()
  );

  p3_side_t                  p3_in;
  p3_side_t                  p3_out;
  logic                      p3_v;
  logic [3*DEN_W-1:0]        den3;
  logic [3*POS_W+2*MU_W-1:0] pm;

  always_comb begin
    p3_in.bad = p2_out.bad;
    p3_in.rr  = p2_out.rr;
    p3_in.rm  = p2_out.rm;
    p3_in.den = p2_out.den;
  end

  osf_mul #(.WA(2*DEN_W), .WB(DEN_W), .NS(NS_P3), .WS($bits(p3_side_t))) u_den3 (
    .clk, .rst_n, .in_valid(p2_v), .in_a(den2), .in_b(p2_out.den), .in_side(p3_in),
    .out_valid(p3_v), .out_prod(den3), .out_side(p3_out)
  );

  osf_mul #(.WA(3*POS_W), .WB(2*MU_W), .NS(NS_P3), .WS(1)) u_pm (
    .clk, .rst_n, .in_valid(p2_v), .in_a(rr3), .in_b(p2_out.mm), .in_side(1'b0),
    .out_valid(), .out_prod(pm), .out_side()
  );

  // time factor
  p3_side_t         t_out;
  logic             t_v;
  logic [TIM_W-1:0] tf;
  logic             tsat;

  osf_seek #(.WN(3*POS_W+2*MU_W+TIM_SHIFT), .WD(3*DEN_W), .WQ(TIM_W), .ROOT(1),
             .WS($bits(p3_side_t))) u_time (
    .clk, .rst_n, .in_valid(p3_v), .in_num({pm, {TIM_SHIFT{1'b0}}}), .in_den(den3),
    .in_side(p3_out), .out_valid(t_v), .out_quo(tf), .out_sat(tsat), .out_side(t_out)
  );

  // length factor
  l_side_t          l_in;
  l_side_t          l_out;
  logic             l_v;
  logic [LEN_W-1:0] lf;
  logic             lsat;

  always_comb begin
    l_in.bad  = t_out.bad;
    l_in.rr   = t_out.rr;
    l_in.den  = t_out.den;
    l_in.tf   = tf;
    l_in.tsat = tsat;
  end

  osf_seek #(.WN(MU_W+POS_W+LEN_SHIFT), .WD(DEN_W), .WQ(LEN_W), .ROOT(0),
             .WS($bits(l_side_t))) u_length (
    .clk, .rst_n, .in_valid(t_v), .in_num({t_out.rm, {LEN_SHIFT{1'b0}}}),
    .in_den(t_out.den), .in_side(l_in), .out_valid(l_v), .out_quo(lf), .out_sat(lsat),
    .out_side(l_out)
  );

  // speed factor
  s_side_t          s_in;
  s_side_t          s_out;
  logic             s_v;
  logic [SPD_W-1:0] sf;
  logic             ssat;

  always_comb begin
    s_in.bad  = l_out.bad;
    s_in.tf   = l_out.tf;
    s_in.tsat = l_out.tsat;
    s_in.lf   = lf;
    s_in.lsat = lsat;
  end

  osf_seek #(.WN(DEN_W), .WD(POS_W), .WQ(SPD_W), .ROOT(1), .WS($bits(s_side_t))) u_speed (
    .clk, .rst_n, .in_valid(l_v), .in_num(l_out.den), .in_den(l_out.rr), .in_side(s_in),
    .out_valid(s_v), .out_quo(sf), .out_sat(ssat), .out_side(s_out)
  );

  // result register
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s_v;
    end
    if (s_out.bad) begin
      out_item_r.length_factor <= '0;
      out_item_r.speed_factor  <= '0;
      out_item_r.time_factor   <= '0;
      out_item_r.status        <= ST_INVALID;
    end else begin
      out_item_r.length_factor <= s_out.lf;
      out_item_r.speed_factor  <= sf;
      out_item_r.time_factor   <= s_out.tf;
      out_item_r.status        <= (s_out.lsat | s_out.tsat | ssat) ? ST_SATURATED : ST_OK;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("item accepted without a result after the pipeline latency");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result without a matching accepted item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status == ST_INVALID) |->
      (out_item.length_factor == '0 && out_item.speed_factor == '0 &&
       out_item.time_factor == '0))
    else $error("invalid state returned nonzero factors");

  a_cfg_reset: assert property (@(posedge clk)
    !rst_n |=> grav_param_r == MU_RESET)
    else $error("gravitational parameter not restored by reset");

endmodule
